// ===== sv/plst_pkg.sv =====
`timescale 1ns / 1ps

package plst_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int WEIGHT_W      = 16;
  localparam int FIXED_W       = 24;
  localparam int LEN_W         = 8;
  localparam int TICKS_W       = 17;
  localparam int DIVIDEND_W    = FIXED_W + LEN_W + 1;
  localparam int STEP_CNT_W    = $clog2(DIVIDEND_W + 1);
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_MOTION = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] ST_EMPTY     = 2'd0;
  localparam logic [1:0] ST_LOADING   = 2'd1;
  localparam logic [1:0] ST_UNLOADING = 2'd2;
  localparam logic [1:0] ST_LOADED    = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_AVERAGE_LENGTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOAD_THRESHOLD   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_MARGIN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXATION_SECONDS = 2'd3;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
  } dp_status_t;

endpackage

// ===== sv/plst_divider.sv =====
`timescale 1ns / 1ps

module plst_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [plst_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [plst_pkg::LEN_W-1:0]      divisor,
  output logic [plst_pkg::DIVIDEND_W-1:0] quotient,
  output logic                            done
);
  import plst_pkg::*;

  logic [DIVIDEND_W-1:0] quo;
  logic [LEN_W-1:0]      rem;
  logic [STEP_CNT_W-1:0] count;
  logic                  busy;
  logic [LEN_W:0]        trial;
  logic [LEN_W:0]        diff;
  logic                  ge;

  assign trial    = {rem, quo[DIVIDEND_W-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= STEP_CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == STEP_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

// ===== sv/plst_datapath.sv =====
`timescale 1ns / 1ps

module plst_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  plst_pkg::ctrl_cmd_t              cmd_bus,
  output plst_pkg::dp_status_t             sts,
  input  logic                             cfg_we,
  input  logic [plst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [plst_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]                       cmd,
  input  logic [plst_pkg::WEIGHT_W-1:0]    weight,
  input  logic                             is_moving,
  output logic                             event_valid,
  output logic [1:0]                       event_code,
  output logic [1:0]                       load_state,
  output logic [plst_pkg::FIXED_W-1:0]     averaged_weight,
  output logic [plst_pkg::FIXED_W-1:0]     fixed_weight
);
  import plst_pkg::*;

  logic [LEN_W-1:0]    average_length;
  logic [WEIGHT_W-1:0] load_threshold;
  logic [WEIGHT_W-1:0] threshold_margin;
  logic [WEIGHT_W-1:0] fixation_seconds;

  logic [1:0]          cap_cmd;
  logic [WEIGHT_W-1:0] cap_weight;
  logic                cap_moving;

  logic               moving_flag,    moving_flag_next;
  logic               over_threshold, over_threshold_next;
  logic               weight_latched, weight_latched_next;
  logic               window_running, window_running_next;
  logic [TICKS_W-1:0] window_ticks,   window_ticks_next;
  logic [FIXED_W-1:0] filter_value,   filter_value_next;
  logic               filter_valid,   filter_valid_next;
  logic [FIXED_W-1:0] average_value,  average_value_next;
  logic [FIXED_W-1:0] latched_value,  latched_value_next;
  logic [1:0]         current_state,  current_state_next;
  logic               ev;
  logic [1:0]         code;

  logic [FIXED_W-1:0]    wf;
  logic [WEIGHT_W:0]     upper;
  logic [WEIGHT_W-1:0]   lower;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVIDEND_W-1:0] quotient;
  logic                  div_done;

  assign wf    = FIXED_W'(cap_weight) << FRACTION_BITS;
  assign upper = {1'b0, load_threshold} + {1'b0, threshold_margin};
  assign lower = (load_threshold > threshold_margin) ? (load_threshold - threshold_margin) : '0;
  assign dividend = DIVIDEND_W'(filter_value) * DIVIDEND_W'(average_length - 1'b1)
                  + DIVIDEND_W'(wf);

  assign sts.needs_div = (cap_cmd == CMD_SAMPLE) && !weight_latched && moving_flag
                       && (average_length > LEN_W'(1)) && filter_valid
                       && (filter_value != '0);
  assign sts.div_done  = div_done;

  plst_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd_bus.div_start),
    .dividend (dividend),
    .divisor  (average_length),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      average_length   <= LEN_W'(10);
      load_threshold   <= WEIGHT_W'(5000);
      threshold_margin <= WEIGHT_W'(200);
      fixation_seconds <= WEIGHT_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AVERAGE_LENGTH:   average_length   <= cfg_data[LEN_W-1:0];
        REG_LOAD_THRESHOLD:   load_threshold   <= cfg_data;
        REG_THRESHOLD_MARGIN: threshold_margin <= cfg_data;
        REG_FIXATION_SECONDS: fixation_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.capture) begin
      cap_cmd    <= cmd;
      cap_weight <= weight;
      cap_moving <= is_moving;
    end
  end

  always_comb begin
    moving_flag_next    = moving_flag;
    over_threshold_next = over_threshold;
    weight_latched_next = weight_latched;
    window_running_next = window_running;
    window_ticks_next   = window_ticks;
    filter_value_next   = filter_value;
    filter_valid_next   = filter_valid;
    average_value_next  = average_value;
    latched_value_next  = latched_value;
    ev                  = 1'b0;
    code                = ST_EMPTY;
    unique case (cap_cmd)
      CMD_SAMPLE: begin
        if (weight_latched) begin
          average_value_next = latched_value;
        end else if (!moving_flag) begin
          filter_valid_next  = 1'b0;
          average_value_next = wf;
        end else begin
          filter_value_next  = sts.needs_div ? quotient[FIXED_W-1:0] : wf;
          filter_valid_next  = 1'b1;
          average_value_next = filter_value_next;
        end
        if (({1'b0, cap_weight} > upper) && !over_threshold) begin
          over_threshold_next = 1'b1;
          if (!moving_flag) begin
            ev   = 1'b1;
            code = ST_LOADING;
          end
        end
        if (cap_weight < lower) begin
          if (over_threshold_next) begin
            ev   = 1'b1;
            code = ST_UNLOADING;
          end
          over_threshold_next = 1'b0;
        end
      end
      CMD_MOTION: begin
        moving_flag_next = cap_moving;
      end
      CMD_TICK: begin
        if (over_threshold) begin
          if (!weight_latched && !window_running && moving_flag) begin
            window_running_next = 1'b1;
            window_ticks_next   = '0;
          end else if (window_running && (window_ticks != TICKS_MAX)) begin
            window_ticks_next = window_ticks + 1'b1;
          end
          if (window_running_next && (window_ticks_next > TICKS_W'(fixation_seconds))) begin
            weight_latched_next = 1'b1;
            window_running_next = 1'b0;
            latched_value_next  = average_value;
            ev                  = 1'b1;
            code                = ST_LOADED;
          end
        end else begin
          weight_latched_next = 1'b0;
          window_running_next = 1'b0;
          if ((current_state == ST_UNLOADING) && moving_flag) begin
            ev                 = 1'b1;
            code               = ST_EMPTY;
            latched_value_next = '0;
          end
        end
      end
      default: ;
    endcase
    current_state_next = ev ? code : current_state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moving_flag    <= 1'b0;
      over_threshold <= 1'b0;
      weight_latched <= 1'b0;
      window_running <= 1'b0;
      window_ticks   <= '0;
      filter_value   <= '0;
      filter_valid   <= 1'b0;
      average_value  <= '0;
      latched_value  <= '0;
      current_state  <= ST_EMPTY;
    end else if (cmd_bus.finish) begin
      moving_flag    <= moving_flag_next;
      over_threshold <= over_threshold_next;
      weight_latched <= weight_latched_next;
      window_running <= window_running_next;
      window_ticks   <= window_ticks_next;
      filter_value   <= filter_value_next;
      filter_valid   <= filter_valid_next;
      average_value  <= average_value_next;
      latched_value  <= latched_value_next;
      current_state  <= current_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.finish) begin
      event_valid     <= ev;
      event_code      <= ev ? code : ST_EMPTY;
      load_state      <= current_state_next;
      averaged_weight <= average_value_next;
      fixed_weight    <= latched_value_next;
    end
  end

endmodule

// ===== sv/plst_ctrl.sv =====
`timescale 1ns / 1ps

module plst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  plst_pkg::dp_status_t sts,
  output plst_pkg::ctrl_cmd_t  cmd_bus
);
  import plst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next        = state;
    cmd_bus.capture   = 1'b0;
    cmd_bus.div_start = 1'b0;
    cmd_bus.finish    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd_bus.capture = 1'b1;
          state_next      = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.needs_div) begin
          cmd_bus.div_start = 1'b1;
          state_next        = S_DIV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_bus.finish = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_bus.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd_bus.finish |-> out_free)
    else $error("result overwritten while still pending");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    cmd_bus.finish |=> result_valid && (state == S_IDLE))
    else $error("finished transaction not presented");

  a_div_only_for_average: assert property (@(posedge clk) disable iff (rst)
    cmd_bus.div_start |-> (state == S_PREP) && sts.needs_div)
    else $error("divider started without averaging sample");

  a_div_leaves_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && sts.div_done |=> (state == S_FIN))
    else $error("divider result not consumed");

endmodule

// ===== sv/payload_load_state_tracker.sv =====
`timescale 1ns / 1ps
// channel  | handshake                  | fields
// item     | item_valid / item_stall    | cmd, weight, is_moving
// result   | result_valid / result_stall| event_valid, event_code, load_state,
//          |                            | averaged_weight, fixed_weight
// config   | cfg_we                     | cfg_index, cfg_data
//
// Motion updates, ticks and plain samples pass through the prepare and final steps
// to the registered result. A moving sample that updates the running average also
// runs the serial divider, one quotient bit per cycle over the 33-bit numerator.
// One item at a time; the next is accepted once the previous result is registered.
// Synchronous active-high reset restores register defaults and the empty state.
// A stalled result holds; the block waits in its final step until the output frees.

module payload_load_state_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [plst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [plst_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       cmd,
  input  logic [plst_pkg::WEIGHT_W-1:0]    weight,
  input  logic                             is_moving,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             event_valid,
  output logic [1:0]                       event_code,
  output logic [1:0]                       load_state,
  output logic [plst_pkg::FIXED_W-1:0]     averaged_weight,
  output logic [plst_pkg::FIXED_W-1:0]     fixed_weight
);
  import plst_pkg::*;

  ctrl_cmd_t  cmd_bus;
  dp_status_t sts;

  plst_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd_bus      (cmd_bus)
  );

  plst_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd_bus         (cmd_bus),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .weight          (weight),
    .is_moving       (is_moving),
    .event_valid     (event_valid),
    .event_code      (event_code),
    .load_state      (load_state),
    .averaged_weight (averaged_weight),
    .fixed_weight    (fixed_weight)
  );

endmodule

// ===== sim/payload_load_state_tracker_check.sv =====
`timescale 1ns / 1ps

module payload_load_state_tracker_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [plst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [plst_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             item_valid,
  input  logic                             item_stall,
  input  logic [1:0]                       cmd,
  input  logic [plst_pkg::WEIGHT_W-1:0]    weight,
  input  logic                             is_moving,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic                             event_valid,
  input  logic [1:0]                       event_code,
  input  logic [1:0]                       load_state,
  input  logic [plst_pkg::FIXED_W-1:0]     averaged_weight,
  input  logic [plst_pkg::FIXED_W-1:0]     fixed_weight,
  output int                               errors,
  output int                               pending,
  output int                               checked,
  output int                               events_seen
);
  import plst_pkg::*;

  typedef struct packed {
    logic               ev;
    logic [1:0]         code;
    logic [1:0]         state;
    logic [FIXED_W-1:0] avg;
    logic [FIXED_W-1:0] fixed;
  } load_report_t;

  load_report_t reports_due[$];

  logic [LEN_W-1:0]    avg_len;
  logic [WEIGHT_W-1:0] thr;
  logic [WEIGHT_W-1:0] margin;
  logic [WEIGHT_W-1:0] fix_secs;

  logic               moving;
  logic               over_thr;
  logic               latched;
  logic               win_run;
  logic [TICKS_W-1:0] win_ticks;
  logic [FIXED_W-1:0] filt;
  logic               filt_ok;
  logic [FIXED_W-1:0] avg_w;
  logic [FIXED_W-1:0] fixed_w;
  logic [1:0]         cur_state;

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    events_seen = 0;
  end

  function automatic load_report_t track_item(input logic [1:0] c, input logic [WEIGHT_W-1:0] w,
                                              input logic m);
    load_report_t rep;
    logic ev;
    logic [1:0] code;
    logic [FIXED_W-1:0] wf;
    logic [WEIGHT_W:0] upper;
    logic [WEIGHT_W-1:0] lower;
    logic [63:0] num;
    ev = 1'b0;
    code = ST_EMPTY;
    wf = FIXED_W'(w) << FRACTION_BITS;
    upper = (WEIGHT_W+1)'(thr) + (WEIGHT_W+1)'(margin);
    lower = (thr > margin) ? thr - margin : '0;
    case (c)
      CMD_SAMPLE: begin
        if (latched) begin
          avg_w = fixed_w;
        end else if (!moving) begin
          filt_ok = 1'b0;
          avg_w = wf;
        end else begin
          if (avg_len > 1 && filt_ok && filt != 0) begin
            num = 64'(filt) * (64'(avg_len) - 64'd1) + 64'(wf);
            filt = FIXED_W'(num / 64'(avg_len));
          end else begin
            filt = wf;
          end
          filt_ok = 1'b1;
          avg_w = filt;
        end
        if ((WEIGHT_W+1)'(w) > upper && !over_thr) begin
          over_thr = 1'b1;
          if (!moving) begin
            ev = 1'b1;
            code = ST_LOADING;
          end
        end
        if (w < lower) begin
          if (over_thr) begin
            ev = 1'b1;
            code = ST_UNLOADING;
          end
          over_thr = 1'b0;
        end
      end
      CMD_MOTION: moving = m;
      CMD_TICK: begin
        if (over_thr) begin
          if (!latched && !win_run && moving) begin
            win_run = 1'b1;
            win_ticks = '0;
          end else if (win_run) begin
            if (win_ticks < TICKS_MAX) win_ticks = win_ticks + 1'b1;
          end
          if (win_run && win_ticks > TICKS_W'(fix_secs)) begin
            latched = 1'b1;
            win_run = 1'b0;
            fixed_w = avg_w;
            ev = 1'b1;
            code = ST_LOADED;
          end
        end else begin
          latched = 1'b0;
          win_run = 1'b0;
          if (cur_state == ST_UNLOADING && moving) begin
            ev = 1'b1;
            code = ST_EMPTY;
            fixed_w = '0;
          end
        end
      end
      default: ;
    endcase
    if (ev) cur_state = code;
    rep.ev = ev;
    rep.code = ev ? code : ST_EMPTY;
    rep.state = cur_state;
    rep.avg = avg_w;
    rep.fixed = fixed_w;
    return rep;
  endfunction

  always @(posedge clk) begin : watch
    load_report_t want;
    load_report_t got;
    if (rst) begin
      avg_len = 8'd10;
      thr = 16'd5000;
      margin = 16'd200;
      fix_secs = 16'd10;
      moving = 1'b0;
      over_thr = 1'b0;
      latched = 1'b0;
      win_run = 1'b0;
      win_ticks = '0;
      filt = '0;
      filt_ok = 1'b0;
      avg_w = '0;
      fixed_w = '0;
      cur_state = ST_EMPTY;
      reports_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        got = {event_valid, event_code, load_state, averaged_weight, fixed_weight};
        checked++;
        if (got.ev) events_seen++;
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: ev %0d code %0d state %0d avg %h fixed %h",
                   $time, got.ev, got.code, got.state, got.avg, got.fixed);
        end else begin
          want = reports_due.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected ev %0d code %0d state %0d avg %h fixed %h",
                     $time, want.ev, want.code, want.state, want.avg, want.fixed);
            $display("%0t:          actual   ev %0d code %0d state %0d avg %h fixed %h",
                     $time, got.ev, got.code, got.state, got.avg, got.fixed);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_AVERAGE_LENGTH:   avg_len = cfg_data[LEN_W-1:0];
          REG_LOAD_THRESHOLD:   thr = cfg_data;
          REG_THRESHOLD_MARGIN: margin = cfg_data;
          REG_FIXATION_SECONDS: fix_secs = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) reports_due.push_back(track_item(cmd, weight, is_moving));
    end
    pending = reports_due.size();
  end

endmodule

// ===== sim/payload_load_state_tracker_tb.sv =====
`timescale 1ns / 1ps

module payload_load_state_tracker_tb;
  import plst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   item_valid;
  logic                   item_stall;
  logic [1:0]             cmd;
  logic [WEIGHT_W-1:0]    weight;
  logic                   is_moving;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   event_valid;
  logic [1:0]             event_code;
  logic [1:0]             load_state;
  logic [FIXED_W-1:0]     averaged_weight;
  logic [FIXED_W-1:0]     fixed_weight;

  int errors;
  int pending;
  int checked;
  int events_seen;

  int items_sent = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  int cur_thr = 5000;
  int cur_margin = 200;
  int cur_fix = 10;

  payload_load_state_tracker dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .weight(weight), .is_moving(is_moving),
    .result_valid(result_valid), .result_stall(result_stall),
    .event_valid(event_valid), .event_code(event_code), .load_state(load_state),
    .averaged_weight(averaged_weight), .fixed_weight(fixed_weight)
  );

  payload_load_state_tracker_check state_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .weight(weight), .is_moving(is_moving),
    .result_valid(result_valid), .result_stall(result_stall),
    .event_valid(event_valid), .event_code(event_code), .load_state(load_state),
    .averaged_weight(averaged_weight), .fixed_weight(fixed_weight),
    .errors(errors), .pending(pending), .checked(checked), .events_seen(events_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver backpressure, independent of result_valid
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet) begin
      result_stall <= 1'b0;
      stall_left <= 8;
    end else begin
      result_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= rand_gap();
    end
  end

  function automatic logic [WEIGHT_W-1:0] any_weight();
    return WEIGHT_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [WEIGHT_W-1:0] heavy_weight();
    int up;
    up = cur_thr + cur_margin;
    if (up >= 65535) return 16'hFFFF;
    return WEIGHT_W'($urandom_range(up + 1, 65535));
  endfunction

  function automatic logic [WEIGHT_W-1:0] light_weight();
    int lo;
    lo = (cur_thr > cur_margin) ? cur_thr - cur_margin : 0;
    if (lo == 0) return '0;
    return WEIGHT_W'($urandom_range(0, lo - 1));
  endfunction

  function automatic logic [WEIGHT_W-1:0] band_weight();
    int lo;
    int up;
    lo = (cur_thr > cur_margin) ? cur_thr - cur_margin : 0;
    up = cur_thr + cur_margin;
    if (up > 65535) up = 65535;
    return WEIGHT_W'($urandom_range(lo, up));
  endfunction

  task automatic send_item(input logic [1:0] c, input logic [WEIGHT_W-1:0] w, input logic m);
    int gap;
    gap = quiet ? 0 : rand_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    weight <= w;
    is_moving <= m;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_phase(input int len, input int thr, input int margin, input int fix,
                           input bit calm);
    drain();
    write_reg(REG_AVERAGE_LENGTH, len);
    write_reg(REG_LOAD_THRESHOLD, thr);
    write_reg(REG_THRESHOLD_MARGIN, margin);
    write_reg(REG_FIXATION_SECONDS, fix);
    cur_thr = thr;
    cur_margin = margin;
    cur_fix = fix;
    quiet = calm;
    settings_used++;
  endtask

  // stop, load, drive off, wait out the fixation window, dump, drive off empty
  task automatic run_trip();
    int n;
    int k;
    logic [WEIGHT_W-1:0] w;
    send_item(CMD_MOTION, any_weight(), 1'b0);
    send_item(CMD_SAMPLE, heavy_weight(), 1'($urandom_range(0, 1)));
    n = $urandom_range(0, 3);
    repeat (n) send_item(CMD_SAMPLE, $urandom_range(0, 1) ? heavy_weight() : band_weight(),
                         1'($urandom_range(0, 1)));
    send_item(CMD_MOTION, any_weight(), 1'b1);
    n = (cur_fix > 20) ? $urandom_range(2, 8) : cur_fix + $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 2) == 0) begin
        w = ($urandom_range(0, 9) == 0) ? light_weight() : heavy_weight();
        send_item(CMD_SAMPLE, w, 1'($urandom_range(0, 1)));
      end
      send_item(CMD_TICK, any_weight(), 1'($urandom_range(0, 1)));
    end
    n = $urandom_range(0, 3);
    repeat (n) send_item(CMD_SAMPLE, $urandom_range(0, 3) ? heavy_weight() : any_weight(),
                         1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) send_item(CMD_MOTION, any_weight(), 1'b0);
    send_item(CMD_SAMPLE, light_weight(), 1'($urandom_range(0, 1)));
    send_item(CMD_MOTION, any_weight(), $urandom_range(0, 4) != 0);
    n = $urandom_range(1, 2);
    repeat (n) send_item(CMD_TICK, any_weight(), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_phase(input int count);
    int target;
    int n;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) != 0) begin
        run_trip();
        if ($urandom_range(0, 9) == 0) drain();
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(2'($urandom_range(0, 3)), any_weight(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    cmd = CMD_SAMPLE;
    weight = '0;
    is_moving = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: ignored command, loading, averaging from zero, loaded, unloading, empty
    send_item(CMD_UNUSED, 16'hFFFF, 1'b1);
    send_item(CMD_SAMPLE, 16'h0000, 1'b1);
    send_item(CMD_SAMPLE, 16'hFFFF, 1'b0);
    send_item(CMD_SAMPLE, 16'd6000, 1'b0);
    send_item(CMD_MOTION, 16'h0000, 1'b1);
    send_item(CMD_SAMPLE, 16'h0000, 1'b0);
    send_item(CMD_SAMPLE, 16'd6000, 1'b1);
    send_item(CMD_SAMPLE, 16'd6400, 1'b0);
    repeat (12) send_item(CMD_TICK, any_weight(), 1'b0);
    send_item(CMD_SAMPLE, 16'd100, 1'b0);
    send_item(CMD_TICK, 16'hFFFF, 1'b1);
    send_item(CMD_MOTION, 16'hFFFF, 1'b0);
    send_item(CMD_SAMPLE, 16'd5100, 1'b1);
    send_item(CMD_TICK, 16'h0000, 1'b0);

    set_phase(0, 0, 0, 0, 1'b0);
    random_phase(60);
    set_phase(255, 65535, 65535, 65535, 1'b0);
    random_phase(30);
    set_phase(1, 300, 500, 3, 1'b1);
    random_phase(70);
    for (p = 0; p < 5; p++) begin
      set_phase($urandom_range(0, 1) ? $urandom_range(2, 16) : $urandom_range(0, 255),
                $urandom_range(100, 60000), $urandom_range(0, 3000), $urandom_range(0, 12),
                1'b0);
      random_phase(64);
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Run covered %0d transactions under %0d register settings,", items_sent,
             settings_used);
    $display("with %0d results compared and %0d load state events.", checked, events_seen);
    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
